### hdl/actr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// actr_pkg
// Shared types, constants and AES-128 round functions for the CTR stream XOR.
// ---------------------------------------------------------------------------
package actr_pkg;

	localparam int unsigned BLOCK_BYTES = 16;
	localparam int unsigned TAIL_START  = 12;
	localparam int unsigned LAST_ROUND  = 10;

	// register indexes on the configuration port
	localparam logic [7:0] REG_KEY_HIGH = 8'd0;
	localparam logic [7:0] REG_KEY_LOW  = 8'd1;
	localparam logic [7:0] REG_IV_HIGH  = 8'd2;
	localparam logic [7:0] REG_IV_LOW   = 8'd3;

	// one classified byte between front end and keystream engine
	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic [3:0]  pos;
		logic [31:0] tail;
	} actr_entry_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] rcon(input logic [3:0] rnd);
		logic [7:0] r;
		case (rnd)
			4'd1:    r = 8'h01;
			4'd2:    r = 8'h02;
			4'd3:    r = 8'h04;
			4'd4:    r = 8'h08;
			4'd5:    r = 8'h10;
			4'd6:    r = 8'h20;
			4'd7:    r = 8'h40;
			4'd8:    r = 8'h80;
			4'd9:    r = 8'h1b;
			4'd10:   r = 8'h36;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	// next round key from the previous one
	function automatic logic [127:0] key_expand(input logic [127:0] rk, input logic [7:0] rc);
		logic [31:0] tmp, w0, w1, w2, w3;
		tmp = {SBOX[rk[23:16]] ^ rc, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
		w0  = rk[127:96] ^ tmp;
		w1  = rk[95:64] ^ w0;
		w2  = rk[63:32] ^ w1;
		w3  = rk[31:0] ^ w2;
		return {w0, w1, w2, w3};
	endfunction

	// one cipher round: subbytes, shiftrows, mixcolumns (skipped in the last round), add key
	function automatic logic [127:0] aes_round(input logic [127:0] st, input logic [127:0] rk,
			input logic final_rnd);
		logic [7:0]   s [16];
		logic [7:0]   t [16];
		logic [7:0]   a0, a1, a2, a3, all;
		logic [127:0] r;
		for (int i = 0; i < 16; i++) begin
			s[i] = st[127 - 8 * i -: 8];
		end
		for (int c = 0; c < 4; c++) begin
			for (int i = 0; i < 4; i++) begin
				t[4 * c + i] = SBOX[s[4 * ((c + i) % 4) + i]];
			end
		end
		if (!final_rnd) begin
			for (int c = 0; c < 4; c++) begin
				a0  = t[4 * c];
				a1  = t[4 * c + 1];
				a2  = t[4 * c + 2];
				a3  = t[4 * c + 3];
				all = a0 ^ a1 ^ a2 ^ a3;
				t[4 * c]     = a0 ^ all ^ xtime(a0 ^ a1);
				t[4 * c + 1] = a1 ^ all ^ xtime(a1 ^ a2);
				t[4 * c + 2] = a2 ^ all ^ xtime(a2 ^ a3);
				t[4 * c + 3] = a3 ^ all ^ xtime(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++) begin
			r[127 - 8 * i -: 8] = t[i];
		end
		return r ^ rk;
	endfunction

endpackage

### hdl/actr_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// actr_front
// Accepts bytes, tracks counter tail and block position, tags each word.
// ---------------------------------------------------------------------------
module actr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           data_in,
	input  logic                 first_byte,
	input  logic [31:0]          block_offset,
	input  logic                 last_in,
	input  logic [31:0]          iv_tail_word,
	input  logic                 q_full,
	output logic                 q_push,
	output actr_pkg::actr_entry_t q_wdata
);
	import actr_pkg::*;

	logic [31:0] counter_tail_q;
	logic [3:0]  byte_pos_q;
	logic [31:0] tail_cur, tail_start, tail_nxt;
	logic [3:0]  pos_cur, pos_nxt;

	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;

	// iv bytes 12..15 read as a little-endian word
	assign tail_start = {iv_tail_word[7:0], iv_tail_word[15:8],
		iv_tail_word[23:16], iv_tail_word[31:24]};

	// counter and position that this word uses
	always_comb begin
		tail_cur = first_byte ? tail_start + block_offset : counter_tail_q;
		pos_cur  = first_byte ? 4'd0 : byte_pos_q;
		pos_nxt  = last_in ? 4'd0 : pos_cur + 4'd1;
		tail_nxt = (pos_nxt == 4'd0) ? tail_cur + 32'd1 : tail_cur;
	end

	assign q_wdata = '{data: data_in, last: last_in, pos: pos_cur, tail: tail_cur};

	// counter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_tail_q <= '0;
			byte_pos_q     <= '0;
		end else if (q_push) begin
			counter_tail_q <= tail_nxt;
			byte_pos_q     <= pos_nxt;
		end
	end

endmodule

### hdl/actr_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// actr_fifo
// Short word queue between front end and keystream engine.
// ---------------------------------------------------------------------------
module actr_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  actr_pkg::actr_entry_t wdata,
	input  logic                  pop,
	output actr_pkg::actr_entry_t rdata,
	output logic                  full,
	output logic                  empty
);
	import actr_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	actr_entry_t   mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hdl/actr_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// actr_core
// Iterative AES-128 keystream engine with byte XOR and output register.
// ---------------------------------------------------------------------------
module actr_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [127:0]          key,
	input  logic [95:0]           iv_head,
	input  logic                  q_empty,
	input  actr_pkg::actr_entry_t q_rdata,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            data_out,
	output logic                  last_out
);
	import actr_pkg::*;

	typedef enum logic {ST_XOR, ST_AES} phase_t;

	phase_t       phase_q;
	logic [127:0] state_q, rk_q, ks_q, next_rk, ks_sh, ctr_blk;
	logic [3:0]   round_q;
	logic         ks_fresh_q, need_blk, out_free, start_aes;
	logic         out_valid_q, last_q;
	logic [7:0]   data_q;

	assign need_blk  = (q_rdata.pos == 4'd0);
	assign out_free  = !out_valid_q || out_ready;
	assign start_aes = (phase_q == ST_XOR) && !q_empty && need_blk && !ks_fresh_q;
	assign q_pop     = (phase_q == ST_XOR) && !q_empty && (!need_blk || ks_fresh_q) && out_free;

	assign ctr_blk = {iv_head, q_rdata.tail[7:0], q_rdata.tail[15:8],
		q_rdata.tail[23:16], q_rdata.tail[31:24]};
	assign next_rk = key_expand(rk_q, rcon(round_q));
	assign ks_sh   = ks_q << {q_rdata.pos, 3'b000};

	assign out_valid = out_valid_q;
	assign data_out  = data_q;
	assign last_out  = last_q;

	// cipher rounds, one per cycle, and the output payload register
	always_ff @(posedge clk) begin
		if (start_aes) begin
			state_q <= ctr_blk ^ key;
			rk_q    <= key;
		end else if (phase_q == ST_AES) begin
			state_q <= aes_round(state_q, next_rk, round_q == 4'(LAST_ROUND));
			rk_q    <= next_rk;
		end
		if (phase_q == ST_AES && round_q == 4'(LAST_ROUND)) begin
			ks_q <= aes_round(state_q, next_rk, 1'b1);
		end
		if (q_pop) begin
			data_q <= q_rdata.data ^ ks_sh[127:120];
			last_q <= q_rdata.last;
		end
	end

	// sequencing and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= ST_XOR;
			round_q     <= '0;
			ks_fresh_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (phase_q)
				ST_XOR: begin
					if (start_aes) begin
						phase_q <= ST_AES;
						round_q <= 4'd1;
					end
				end
				ST_AES: begin
					round_q <= round_q + 4'd1;
					if (round_q == 4'(LAST_ROUND)) begin
						phase_q    <= ST_XOR;
						ks_fresh_q <= 1'b1;
					end
				end
				default: phase_q <= ST_XOR;
			endcase
			if (q_pop && need_blk) begin
				ks_fresh_q <= 1'b0;
			end
			if (q_pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### hdl/aes128_ctr_stream_xor.sv
`timescale 1ns / 1ps
// path: queue, then output register; a block's first byte also waits for its keystream
// throughput: one byte per cycle inside a block while the output is not stalled; each new
// block runs the initial key add plus ten rounds in the shared round unit, one per cycle
// reset: arst_n clears key, iv, counter tail, block position, queue, sequencer and output
// valid; keystream and payload registers are not reset
// ---------------------------------------------------------------------------
// aes128_ctr_stream_xor
// AES-128 counter-mode stream XOR, byte wide, with register write port.
// ---------------------------------------------------------------------------
module aes128_ctr_stream_xor #(
	parameter int unsigned FIFO_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // data_in [7:0], block_offset [39:8]
	input  logic        s_axis_tuser,   // first_byte
	input  logic        s_axis_tlast,   // last_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // data_out [7:0]
	output logic        m_axis_tlast,   // last_out
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import actr_pkg::*;

	logic [63:0] key_high_q, key_low_q, iv_high_q, iv_low_q;
	actr_entry_t q_wdata, q_rdata;
	logic        q_push, q_pop, q_full, q_empty;

	assign cfg_ready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			iv_high_q  <= '0;
			iv_low_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_KEY_HIGH: key_high_q <= cfg_data;
				REG_KEY_LOW:  key_low_q  <= cfg_data;
				REG_IV_HIGH:  iv_high_q  <= cfg_data;
				REG_IV_LOW:   iv_low_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	actr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.data_in      (s_axis_tdata[7:0]),
		.first_byte   (s_axis_tuser),
		.block_offset (s_axis_tdata[39:8]),
		.last_in      (s_axis_tlast),
		.iv_tail_word (iv_low_q[31:0]),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_wdata      (q_wdata)
	);

	actr_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	actr_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.key       ({key_high_q, key_low_q}),
		.iv_head   ({iv_high_q, iv_low_q[63:32]}),
		.q_empty   (q_empty),
		.q_rdata   (q_rdata),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.data_out  (m_axis_tdata),
		.last_out  (m_axis_tlast)
	);

endmodule

### hdl/actr_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// actr_checker
// Port-level checks on the CTR stream XOR, bound to the top level.
// ---------------------------------------------------------------------------
module actr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,
	input logic        m_axis_tlast,
	input logic        cfg_ready
);

	// a stalled output word holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast))
		else $error("output word changed while stalled");

	// output valid stays low while reset is held
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !m_axis_tvalid)
		else $error("output valid during reset");

	// register port never stalls
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port not ready");

	// no output word in the cycle in which reset release is first seen
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !m_axis_tvalid)
		else $error("output word without accepted input");

endmodule

bind aes128_ctr_stream_xor actr_checker u_actr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.cfg_ready     (cfg_ready)
);

### verif/tb_aes128_ctr_stream_xor.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_aes128_ctr_stream_xor
// Self-checking bench for the counter-mode stream XOR. A scoreboard keeps its
// own key, iv and counter state, computes the keystream per block and checks
// every output word in order. Directed messages come first, then random
// messages under three idling patterns, with register changes between phases.
// ---------------------------------------------------------------------------
module tb_aes128_ctr_stream_xor;
	import actr_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} xor_word_t;

	// mismatch reporting
	int unsigned error_count = 0;

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("mismatch %s: got %02h, want %02h", what, got, want);
		error_count++;
	endtask

	// scoreboard: keystream predictor plus queue of expected words
	class ctr_scoreboard;
		logic [63:0] key_hi, key_lo, iv_hi, iv_lo;
		logic [31:0] tail;
		logic [3:0]  pos;
		logic [7:0]  ks [16];
		xor_word_t   pending [$];

		function new();
			key_hi = '0; key_lo = '0; iv_hi = '0; iv_lo = '0;
			tail = '0; pos = '0;
		endfunction

		function void write_reg(input logic [7:0] idx, input logic [63:0] val);
			case (idx)
				REG_KEY_HIGH: key_hi = val;
				REG_KEY_LOW:  key_lo = val;
				REG_IV_HIGH:  iv_hi = val;
				REG_IV_LOW:   iv_lo = val;
				default: ;
			endcase
		endfunction

		function logic [7:0] gmul2(input logic [7:0] b);
			return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
		endfunction

		// encrypt one counter block into the keystream buffer
		function void refill_keystream();
			logic [7:0] rk [176];
			logic [7:0] st [16];
			logic [7:0] t [16];
			logic [7:0] a, b, d, e, tmp, x0, x1, x2, x3, all;
			logic [7:0] rc;
			for (int i = 0; i < 8; i++) begin
				rk[i]     = key_hi[63 - 8 * i -: 8];
				rk[i + 8] = key_lo[63 - 8 * i -: 8];
				st[i]     = iv_hi[63 - 8 * i -: 8];
				st[i + 8] = iv_lo[63 - 8 * i -: 8];
			end
			for (int i = 0; i < 4; i++) st[TAIL_START + i] = tail[8 * i +: 8];
			rc = 8'h01;
			for (int i = 16; i < 176; i += 4) begin
				a = rk[i - 4]; b = rk[i - 3]; d = rk[i - 2]; e = rk[i - 1];
				if (i % 16 == 0) begin
					tmp = a;
					a = SBOX[b] ^ rc; b = SBOX[d]; d = SBOX[e]; e = SBOX[tmp];
					rc = gmul2(rc);
				end
				rk[i] = rk[i - 16] ^ a; rk[i + 1] = rk[i - 15] ^ b;
				rk[i + 2] = rk[i - 14] ^ d; rk[i + 3] = rk[i - 13] ^ e;
			end
			for (int i = 0; i < 16; i++) st[i] ^= rk[i];
			for (int r = 1; r <= 10; r++) begin
				for (int c = 0; c < 4; c++)
					for (int i = 0; i < 4; i++) t[4 * c + i] = SBOX[st[4 * ((c + i) % 4) + i]];
				if (r != 10) begin
					for (int c = 0; c < 4; c++) begin
						x0 = t[4 * c]; x1 = t[4 * c + 1]; x2 = t[4 * c + 2]; x3 = t[4 * c + 3];
						all = x0 ^ x1 ^ x2 ^ x3;
						t[4 * c]     = x0 ^ all ^ gmul2(x0 ^ x1);
						t[4 * c + 1] = x1 ^ all ^ gmul2(x1 ^ x2);
						t[4 * c + 2] = x2 ^ all ^ gmul2(x2 ^ x3);
						t[4 * c + 3] = x3 ^ all ^ gmul2(x3 ^ x0);
					end
				end
				for (int i = 0; i < 16; i++) st[i] = t[i] ^ rk[16 * r + i];
			end
			for (int i = 0; i < 16; i++) ks[i] = st[i];
		endfunction

		// note an accepted input byte and queue its expected output
		function void note_input(input logic [7:0] data, input logic first,
				input logic [31:0] offset, input logic last);
			xor_word_t w;
			if (first) begin
				tail = {iv_lo[7:0], iv_lo[15:8], iv_lo[23:16], iv_lo[31:24]} + offset;
				pos = '0;
			end
			if (pos == 0) refill_keystream();
			w.data = data ^ ks[pos];
			w.last = last;
			pending.push_back(w);
			pos = pos + 1'b1;
			if (last) pos = '0;
			if (pos == 0) tail = tail + 1;
		endfunction

		task check_output(input logic [7:0] data, input logic last);
			xor_word_t w;
			if (pending.size() == 0) begin
				report_mismatch("unexpected word", data, 8'h00);
				return;
			end
			w = pending.pop_front();
			if (data !== w.data) report_mismatch("data", data, w.data);
			if (last !== w.last) report_mismatch("last", {7'd0, last}, {7'd0, w.last});
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;  // data_in [7:0], block_offset [39:8]
	logic        s_axis_tuser = 1'b0; // first_byte
	logic        s_axis_tlast = 1'b0; // last_in
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;        // data_out [7:0]
	logic        m_axis_tlast;        // last_out
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned quiet_cycles = 0;
	ctr_scoreboard sb = new();

	aes128_ctr_stream_xor DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random stalls, checks at the rising edge
	always @(negedge clk) begin
		if (arst_n) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) sb.check_output(m_axis_tdata, m_axis_tlast);
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// valid stays high between back-to-back writes, the caller drops it
	task automatic write_reg(input logic [7:0] idx, input logic [63:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		@(negedge clk);
	endtask

	// wait for every expected word, then let the cipher pipeline drain
	task automatic drain();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic load_regs(input logic [63:0] kh, input logic [63:0] kl,
			input logic [63:0] ih, input logic [63:0] il);
		drain();
		write_reg(REG_KEY_HIGH, kh);
		write_reg(REG_KEY_LOW, kl);
		write_reg(REG_IV_HIGH, ih);
		write_reg(REG_IV_LOW, il);
		cfg_valid <= 1'b0;
	endtask

	// send one byte, idling first at random
	task automatic send_byte(input logic [7:0] data, input logic first,
			input logic [31:0] offset, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {offset, data};
		s_axis_tuser  <= first;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(data, first, offset, last);
		@(negedge clk);
	endtask

	task automatic stop_sending();
		s_axis_tvalid <= 1'b0;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [31:0] rand_offset();
		case ($urandom_range(3))
			0: return 32'hffff_ffff - $urandom_range(3);
			1: return $urandom_range(3);
			default: return $urandom();
		endcase
	endfunction

	// random messages, mostly well formed, some without a start or an end
	task automatic random_messages(input int unsigned n_bytes);
		int unsigned sent;
		int unsigned len;
		sent = 0;
		while (sent < n_bytes) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 35);
			for (int i = 0; i < len; i++) begin
				send_byte(8'($urandom()),
					(i == 0 && $urandom_range(9) != 0) || $urandom_range(60) == 0,
					rand_offset(),
					(i == len - 1 && $urandom_range(9) != 0) || $urandom_range(60) == 0);
				sent++;
			end
		end
		stop_sending();
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: bytes before any start run from tail zero with reset registers
		send_byte(8'h00, 1'b0, 32'h0, 1'b0);
		send_byte(8'hff, 1'b0, 32'hffff_ffff, 1'b1);
		stop_sending();
		// one-byte message and first and last together, extreme registers and offsets
		load_regs('1, '1, '1, '1);
		send_byte(8'h5a, 1'b1, 32'hffff_ffff, 1'b1);
		send_byte(8'ha5, 1'b1, 32'h0000_0001, 1'b1);
		// full block then a short one, tail wrap through the end of the range
		for (int i = 0; i < 19; i++)
			send_byte(i[7:0] * 8'd13, i == 0, 32'h0000_0000, i == 18);
		stop_sending();
		// pause until everything has come out, then new registers and a two-byte message
		load_regs(64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f, '0, '0);
		send_byte(8'h11, 1'b1, 32'h8000_0000, 1'b0);
		send_byte(8'h22, 1'b0, 32'h0, 1'b1);
		stop_sending();

		// random phases with different idling
		load_regs(rand64(), rand64(), rand64(), rand64());
		send_idle_pct = 11; recv_idle_pct = 61;
		random_messages(360);
		load_regs(rand64(), rand64(), rand64(), 64'hffff_ffff_ffff_ffff);
		send_idle_pct = 61; recv_idle_pct = 11;
		random_messages(360);
		load_regs(rand64(), rand64(), rand64(), rand64());
		send_idle_pct = 0; recv_idle_pct = 0;
		random_messages(360);

		drain();
		if (error_count == 0 && sb.pending.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

### sim.f
hdl/actr_pkg.sv
hdl/actr_front.sv
hdl/actr_fifo.sv
hdl/actr_core.sv
hdl/aes128_ctr_stream_xor.sv
hdl/actr_checker.sv
verif/tb_aes128_ctr_stream_xor.sv
